FILE: hw/rtl/crc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package crc_pkg;

  // event kinds on the input stream
  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_TICK  = 2'd1,
    REQ_ACK   = 2'd2
  } req_e;

  // configuration register indexes
  localparam logic [7:0] CFG_ACK_TIMEOUT = 8'd0;
  localparam logic [7:0] CFG_RANDOM_SPAN = 8'd1;
  localparam logic [7:0] CFG_MAX_RETX    = 8'd2;
  localparam logic [7:0] CFG_START_ID    = 8'd3;

  // reset values of the registers
  localparam logic [15:0] ACK_TIMEOUT_RST = 16'd2000;
  localparam logic [15:0] RANDOM_SPAN_RST = 16'd1000;
  localparam logic [3:0]  MAX_RETX_RST    = 4'd4;
  localparam logic [15:0] START_ID_RST    = 16'd0;

  localparam int unsigned ID_W    = 16;
  localparam int unsigned RTT_W   = 24;
  localparam int unsigned RETRY_W = 5;
  // width of base timeout plus scaled random part
  localparam int unsigned FRESH_W = 17;

  typedef struct packed {
    logic [15:0] base_tmo;
    logic [15:0] random_span;
    logic [3:0]  max_retx;
    logic [15:0] start_id;
  } cfg_t;

  typedef struct packed {
    req_e            req;
    logic [ID_W-1:0] ack_id;
  } item_t;

  typedef struct packed {
    logic [ID_W-1:0]  send_id;
    logic             is_retx;
    logic             gave_up;
    logic             ack_matched;
    logic [RTT_W-1:0] rtt;
  } res_t;

endpackage

`default_nettype wire

FILE: hw/rtl/crc_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module crc_cfg_regs
  import crc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  output cfg_t             cfg_o
);

  cfg_t cfg_d, cfg_q;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_ACK_TIMEOUT: cfg_d.base_tmo    = cfg_data_i;
        CFG_RANDOM_SPAN: cfg_d.random_span = cfg_data_i;
        CFG_MAX_RETX:    cfg_d.max_retx    = cfg_data_i[3:0];
        CFG_START_ID:    cfg_d.start_id    = cfg_data_i;
        default:         cfg_d = cfg_q;  // writes past the list are dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base_tmo    <= ACK_TIMEOUT_RST;
      cfg_q.random_span <= RANDOM_SPAN_RST;
      cfg_q.max_retx    <= MAX_RETX_RST;
      cfg_q.start_id    <= START_ID_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: hw/rtl/crc_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module crc_in_stage
  import crc_pkg::*;
#(
  parameter int unsigned TIMER_BITS = 24
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_valid_i,
  output logic                       s_ready_o,
  input  wire logic [1:0]            s_req_i,
  input  wire logic [ID_W-1:0]       s_ack_id_i,
  input  wire logic [7:0]            s_rnd_i,
  input  wire cfg_t                  cfg_i,
  input  wire logic                  take_i,
  output logic                       valid_o,
  output item_t                      item_o,
  output logic [TIMER_BITS-1:0]      fresh_o
);

  logic                  valid_q;
  item_t                 item_q;
  logic [TIMER_BITS-1:0] fresh_d, fresh_q;
  logic [23:0]           prod;
  logic [FRESH_W-1:0]    sum;
  logic                  accept;

  // fresh timeout: base + floor(span * rnd / 256), worked out on the way in
  assign prod = cfg_i.random_span * s_rnd_i;
  assign sum  = {1'b0, cfg_i.base_tmo} + {1'b0, prod[23:8]};

  if (TIMER_BITS >= FRESH_W) begin : g_fresh_wide
    assign fresh_d = TIMER_BITS'(sum);
  end else begin : g_fresh_sat
    assign fresh_d = (|sum[FRESH_W-1:TIMER_BITS]) ? '1 : sum[TIMER_BITS-1:0];
  end

  assign s_ready_o = !valid_q || take_i;
  assign accept    = s_valid_i && s_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.req    <= req_e'(s_req_i);
      item_q.ack_id <= s_ack_id_i;
      fresh_q       <= fresh_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;
  assign fresh_o = fresh_q;

endmodule

`default_nettype wire

FILE: hw/rtl/crc_core.sv
`timescale 1ns / 1ps
`default_nettype none

module crc_core
  import crc_pkg::*;
#(
  parameter int unsigned TIMER_BITS = 24
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cfg_t             cfg_i,
  input  wire logic             in_valid_i,
  input  wire item_t            item_i,
  input  wire logic [TIMER_BITS-1:0] fresh_i,
  output logic                  take_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output res_t                  res_o
);

  localparam logic [TIMER_BITS-1:0] TMAX = '1;
  localparam logic [TIMER_BITS-1:0] TONE = TIMER_BITS'(1);

  logic [ID_W-1:0]       id_d, id_q;
  logic [RETRY_W-1:0]    retry_d, retry_q;
  logic [TIMER_BITS-1:0] tlen_d, tlen_q;
  logic [TIMER_BITS-1:0] trem_d, trem_q;
  logic [TIMER_BITS-1:0] elap_d, elap_q;
  logic                  run_d, run_q;

  logic                  out_valid_q;
  res_t                  out_q;

  logic [TIMER_BITS-1:0] dbl;
  logic [TIMER_BITS-1:0] elap_inc;
  logic [RETRY_W-1:0]    retry_inc;
  logic [ID_W-1:0]       id_inc;
  logic [RTT_W-1:0]      rtt_sat;
  logic                  emit;
  res_t                  res;

  assign dbl       = tlen_q[TIMER_BITS-1] ? TMAX : {tlen_q[TIMER_BITS-2:0], 1'b0};
  assign elap_inc  = (elap_q == TMAX) ? elap_q : elap_q + TONE;
  assign retry_inc = retry_q + RETRY_W'(1);
  assign id_inc    = id_q + ID_W'(1);

  if (TIMER_BITS <= RTT_W) begin : g_rtt_narrow
    assign rtt_sat = RTT_W'(elap_q);
  end else begin : g_rtt_sat
    assign rtt_sat = (|elap_q[TIMER_BITS-1:RTT_W]) ? '1 : elap_q[RTT_W-1:0];
  end

  // one item goes through when the result register is free or being drained
  assign take_o = in_valid_i && (!out_valid_q || out_ready_i);

  always_comb begin
    id_d    = id_q;
    retry_d = retry_q;
    tlen_d  = tlen_q;
    trem_d  = trem_q;
    elap_d  = elap_q;
    run_d   = run_q;
    emit    = 1'b0;
    res     = '0;
    res.send_id = id_q;
    unique case (item_i.req)
      REQ_START: begin
        id_d        = cfg_i.start_id;
        tlen_d      = fresh_i;
        trem_d      = fresh_i;
        elap_d      = '0;
        retry_d     = '0;
        run_d       = 1'b1;
        emit        = 1'b1;
        res.send_id = cfg_i.start_id;
      end
      REQ_TICK: begin
        if (run_q) begin
          elap_d = elap_inc;
          if (trem_q > TONE) begin
            trem_d = trem_q - TONE;
          end else if (retry_inc <= {1'b0, cfg_i.max_retx}) begin
            // timer expired, still within the limit: resend
            retry_d     = retry_inc;
            tlen_d      = dbl;
            trem_d      = dbl;
            emit        = 1'b1;
            res.is_retx = 1'b1;
          end else begin
            // limit passed: drop this ID and move on
            id_d        = id_inc;
            tlen_d      = fresh_i;
            trem_d      = fresh_i;
            elap_d      = '0;
            retry_d     = '0;
            emit        = 1'b1;
            res.send_id = id_inc;
            res.gave_up = 1'b1;
          end
        end
      end
      REQ_ACK: begin
        if (run_q) begin
          emit = 1'b1;
          if (item_i.ack_id == id_q) begin
            id_d            = id_inc;
            tlen_d          = fresh_i;
            trem_d          = fresh_i;
            elap_d          = '0;
            retry_d         = '0;
            res.send_id     = id_inc;
            res.ack_matched = 1'b1;
            res.rtt         = rtt_sat;
          end else begin
            // stale ack: resend with a doubled timer, count untouched
            tlen_d      = dbl;
            trem_d      = dbl;
            res.is_retx = 1'b1;
          end
        end
      end
      default: begin
        emit = 1'b0;  // unused kind
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_q        <= '0;
      retry_q     <= '0;
      tlen_q      <= '0;
      trem_q      <= '0;
      elap_q      <= '0;
      run_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take_o) begin
        id_q    <= id_d;
        retry_q <= retry_d;
        tlen_q  <= tlen_d;
        trem_q  <= trem_d;
        elap_q  <= elap_d;
        run_q   <= run_d;
      end
      if (take_o && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = out_q;

  // a start always puts start_id out next
  a_start_sends_start_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o && item_i.req == REQ_START |=>
      out_valid_q && out_q.send_id == $past(cfg_i.start_id))
    else $error("start did not send start_id");

  // at most one of the result flags
  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> $onehot0({out_q.is_retx, out_q.gave_up, out_q.ack_matched}))
    else $error("result flags not exclusive");

  // a tick on a running timer above one only counts it down
  a_tick_countdown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o && run_q && item_i.req == REQ_TICK && trem_q > TONE |=>
      trem_q == $past(trem_q) - TONE && id_q == $past(id_q))
    else $error("timer countdown broken");

  // once started the controller never goes idle again
  a_run_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q |=> run_q)
    else $error("running flag dropped");

  // round trip only reported on a matched ack
  a_rtt_only_on_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.ack_matched |-> out_q.rtt == '0)
    else $error("round trip reported without a match");

endmodule

`default_nettype wire

FILE: hw/rtl/confirmable_retransmit_controller.sv
`timescale 1ns / 1ps
`default_nettype none

// confirmable-message retransmission controller, sender side
//
// s_axis: one event per transfer, tuser carries the kind (start, tick, ack),
//   tdata the acked message ID and a random byte for a freshly armed timer
// m_axis: one send per transfer (message ID, retransmit / gave-up / matched
//   flags, round-trip ticks on a matched ack); ticks that only count the
//   timer down produce no transfer
// cfg: register writes, always ready; write only while idle
//
// path: an event lands in the input register; once the core takes it, it
//   updates the controller state and loads the result register, which
//   drives m_axis_tvalid_o; a held-off m_axis can keep the event waiting
//   in the input register in between
// throughput: one event per cycle while m_axis is not held off; the state
//   update is one pass of compare, decrement and add, and the small
//   random-span multiply sits in front of the input register
// stall: while m_axis is held off with a result waiting, the core stops and
//   s_axis_tready_o drops once the input register is full
// reset: registers return to their defaults, the controller is idle and
//   ignores ticks and acks until a start event arrives
module confirmable_retransmit_controller
  import crc_pkg::*;
#(
  parameter int unsigned TIMER_BITS = 24  // timer width, 16 to 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // event stream
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [23:0] s_axis_tdata_i,  // [15:0] ack_id, [23:16] random_byte
  input  wire logic [1:0]  s_axis_tuser_i,  // [1:0] req_type
  // send stream
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [39:0]      m_axis_tdata_o,  // [15:0] send_id, [39:16] round_trip_ticks
  output logic [2:0]       m_axis_tuser_o,  // [0] is_retransmit, [1] gave_up,
                                            // [2] ack_matched
  // register writes
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  cfg_t                  cfg;
  logic                  take;
  logic                  item_valid;
  item_t                 item;
  logic [TIMER_BITS-1:0] fresh;
  res_t                  res;

  crc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // input register, also precomputes the fresh timeout
  crc_in_stage #(
    .TIMER_BITS (TIMER_BITS)
  ) u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid_i),
    .s_ready_o  (s_axis_tready_o),
    .s_req_i    (s_axis_tuser_i),
    .s_ack_id_i (s_axis_tdata_i[15:0]),
    .s_rnd_i    (s_axis_tdata_i[23:16]),
    .cfg_i      (cfg),
    .take_i     (take),
    .valid_o    (item_valid),
    .item_o     (item),
    .fresh_o    (fresh)
  );

  // state update and result register
  crc_core #(
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (item_valid),
    .item_i      (item),
    .fresh_i     (fresh),
    .take_o      (take),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .res_o       (res)
  );

  assign m_axis_tdata_o = {res.rtt, res.send_id};
  assign m_axis_tuser_o = {res.ack_matched, res.gave_up, res.is_retx};

endmodule

`default_nettype wire
